// ===== src/kte_pkg.sv =====
// Package for the keyed table with expiry: commands, status codes, sequencer
// states and the request and response structs shared by the control and top files.
// No dependencies.
package kte_pkg;

  // Fixed field widths of the stream payload.
  localparam int KEY_W     = 16;
  localparam int DIM_W     = 8;
  localparam int PAY_W     = 32;
  localparam int LIFE_W    = 16;
  localparam int EXP_CNT_W = 9;

  // Lifespan given to an entry inserted with a lifespan of zero.
  localparam logic [LIFE_W-1:0] DEFAULT_LIFESPAN = 16'd1000;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_AGE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_DUP     = 2'd1,
    STS_MISSING = 2'd2,
    STS_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [DIM_W-1:0]  dimension;
    logic [PAY_W-1:0]  payload;
    logic [LIFE_W-1:0] lifespan;
    logic [LIFE_W-1:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic                 ok;
    status_t              status;
    logic [PAY_W-1:0]     found_payload;
    logic [LIFE_W-1:0]    lifespan_left;
    logic [EXP_CNT_W-1:0] expired_count;
  } rsp_t;

endpackage

// ===== src/kte_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module kte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/kte_ctrl.sv =====
// Sequencer of the keyed table: scans the entry RAM one slot per cycle through a
// shared pair compare and lifespan subtract unit, and holds valid bits and the result.
// Depends on kte_pkg.
module kte_ctrl #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int WORD_W = kte_pkg::KEY_W + kte_pkg::DIM_W + PAYLOAD_BITS + kte_pkg::LIFE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kte_pkg::req_t      in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output kte_pkg::rsp_t      out_rsp,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_wr_addr,
  output logic [WORD_W-1:0]  ram_wr_data,
  output logic               ram_rd_en,
  output logic [IDX_W-1:0]   ram_rd_addr,
  input  logic [WORD_W-1:0]  ram_rd_data
);
  import kte_pkg::*;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int PAY_LSB = KEY_W + DIM_W;
  localparam int LIFE_LSB = PAY_LSB + PAYLOAD_BITS;

  state_t                state_r, state_nxt;
  req_t                  req_r, req_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]      p_idx_r, p_idx_nxt;
  logic [CAPACITY-1:0]   valid_r, valid_nxt;
  logic                  hit_r, hit_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [PAYLOAD_BITS-1:0] fpay_r, fpay_nxt;
  logic [LIFE_W-1:0]     fleft_r, fleft_nxt;
  logic [EXP_CNT_W-1:0]  exp_r, exp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  out_r, out_nxt;

  logic [KEY_W-1:0]        e_key;
  logic [DIM_W-1:0]        e_dim;
  logic [PAYLOAD_BITS-1:0] e_pay;
  logic [LIFE_W-1:0]       e_life;
  logic                    pair_eq;
  logic [LIFE_W:0]         diff;
  logic                    expire;
  logic                    slot_v;
  logic [63:0]             pay_in_ext;
  logic [63:0]             fpay_ext;
  logic [LIFE_W-1:0]       ins_life;
  logic                    out_load;
  rsp_t                    rsp;

  // Fields of the entry returned by the RAM.
  assign e_key  = ram_rd_data[KEY_W-1:0];
  assign e_dim  = ram_rd_data[KEY_W +: DIM_W];
  assign e_pay  = ram_rd_data[PAY_LSB +: PAYLOAD_BITS];
  assign e_life = ram_rd_data[LIFE_LSB +: LIFE_W];

  // Shared unit: pair compare and one lifespan subtractor with borrow.
  assign pair_eq = (e_key == req_r.key) && (e_dim == req_r.dimension);
  assign diff    = {1'b0, e_life} - {1'b0, req_r.elapsed_ms};
  assign expire  = diff[LIFE_W] || (diff[LIFE_W-1:0] == '0);
  assign slot_v  = valid_r[p_idx_r];

  // Payload width conversions between the 32-bit field and the stored width.
  assign pay_in_ext = {32'd0, req_r.payload};
  assign fpay_ext   = 64'(fpay_r);
  assign ins_life   = (req_r.lifespan == '0) ? DEFAULT_LIFESPAN : req_r.lifespan;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // Result of the finished operation.
  always_comb begin
    rsp = '0;
    unique case (req_r.cmd)
      CMD_INSERT: begin
        if (hit_r) begin
          rsp.status = STS_DUP;
        end else if (!free_found_r) begin
          rsp.status = STS_FULL;
        end else begin
          rsp.ok     = 1'b1;
          rsp.status = STS_OK;
        end
      end
      CMD_FIND: begin
        if (hit_r) begin
          rsp.ok            = 1'b1;
          rsp.status        = STS_OK;
          rsp.found_payload = fpay_ext[PAY_W-1:0];
          rsp.lifespan_left = fleft_r;
        end else begin
          rsp.status = STS_MISSING;
        end
      end
      CMD_ERASE: begin
        if (hit_r) begin
          rsp.ok     = 1'b1;
          rsp.status = STS_OK;
        end else begin
          rsp.status = STS_MISSING;
        end
      end
      CMD_AGE: begin
        rsp.ok            = 1'b1;
        rsp.status        = STS_OK;
        rsp.expired_count = exp_r;
      end
    endcase
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    valid_nxt      = valid_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    fpay_nxt       = fpay_r;
    fleft_nxt      = fleft_r;
    exp_nxt        = exp_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = cnt_r[IDX_W-1:0];
    ram_we         = 1'b0;
    ram_wr_addr    = p_idx_r;
    ram_wr_data    = {diff[LIFE_W-1:0], ram_rd_data[LIFE_LSB-1:0]};
    out_load       = 1'b0;

    // The output register empties when its beat is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req;
          cnt_nxt        = '0;
          p_vld_nxt      = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          exp_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one slot read per cycle until every slot is requested.
        if (cnt_r < CNT_W'(CAPACITY)) begin
          ram_rd_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          p_vld_nxt = 1'b1;
          p_idx_nxt = cnt_r[IDX_W-1:0];
        end else begin
          p_vld_nxt = 1'b0;
        end

        // Examine the slot whose data has just come back.
        if (p_vld_r) begin
          if (req_r.cmd == CMD_AGE) begin
            if (slot_v) begin
              if (expire) begin
                valid_nxt[p_idx_r] = 1'b0;
                exp_nxt            = exp_r + 1'b1;
              end else begin
                ram_we = 1'b1;
              end
            end
          end else begin
            if (slot_v && pair_eq) begin
              hit_nxt   = 1'b1;
              fpay_nxt  = e_pay;
              fleft_nxt = e_life;
              if (req_r.cmd == CMD_ERASE) begin
                valid_nxt[p_idx_r] = 1'b0;
              end
            end
            if (!slot_v && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = p_idx_r;
            end
          end
          if (cnt_r == CNT_W'(CAPACITY)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // Wait for room in the output register, then load the result and commit a successful insert.
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          out_nxt       = rsp;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (req_r.cmd == CMD_INSERT && !hit_r && free_found_r) begin
            ram_we                  = 1'b1;
            ram_wr_addr             = free_idx_r;
            ram_wr_data             = {ins_life, pay_in_ext[PAYLOAD_BITS-1:0],
                                       req_r.dimension, req_r.key};
            valid_nxt[free_idx_r]   = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      p_vld_r      <= 1'b0;
      valid_r      <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      p_vld_r      <= p_vld_nxt;
      valid_r      <= valid_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    p_idx_r    <= p_idx_nxt;
    free_idx_r <= free_idx_nxt;
    fpay_r     <= fpay_nxt;
    fleft_r    <= fleft_nxt;
    exp_r      <= exp_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== src/keyed_table_with_expiry.sv =====
// Top level of the keyed table with expiry: stream ports, field packing, entry RAM
// and the scanning sequencer.
// Depends on kte_pkg, kte_ram and kte_ctrl.
//
//   Channel   Ports                            Beat carries
//   input     in_tvalid/in_tready/in_t*        one command with key, pair and values
//   output    out_tvalid/out_tready/out_t*     one result per command
//
// Every command scans all CAPACITY slots of the entry RAM, one slot per cycle
// through its single read port, before the next command can be accepted.
// Reset clears the valid bits and the sequencer at once; no clearing pass runs.
// A result waits in the output register; a later command holds in its last
// cycle until that register is free, and in_tready is low while a command runs.
module keyed_table_with_expiry #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // key [15:0], dimension [23:16], payload [55:24], lifespan [71:56],
  // elapsed_ms [87:72]
  input  logic [87:0] in_tdata,
  // cmd [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // found_payload [31:0], lifespan_left [47:32], expired_count [56:48], zero [63:57]
  output logic [63:0] out_tdata,
  // ok [0], status [2:1]
  output logic [2:0]  out_tuser
);
  import kte_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WORD_W = KEY_W + DIM_W + PAYLOAD_BITS + LIFE_W;

  req_t              req;
  rsp_t              rsp;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  // Unpack the input beat.
  assign req.cmd        = cmd_t'(in_tuser[1:0]);
  assign req.key        = in_tdata[15:0];
  assign req.dimension  = in_tdata[23:16];
  assign req.payload    = in_tdata[55:24];
  assign req.lifespan   = in_tdata[71:56];
  assign req.elapsed_ms = in_tdata[87:72];

  // Pack the result beat.
  assign out_tdata = {7'd0, rsp.expired_count, rsp.lifespan_left, rsp.found_payload};
  assign out_tuser = {rsp.status, rsp.ok};

  // Entry store: key, dimension, payload and lifespan of each slot.
  kte_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Scanning sequencer with valid bits and output register.
  kte_ctrl #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (req),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rsp     (rsp),
    .ram_we      (ram_we),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

// ===== bench/keyed_table_with_expiry_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keyed_table_with_expiry: a directed script and then random
// commands on the input stream, with every result compared against a table predictor or a result typed into the script.
// Depends on kte_pkg and the keyed_table_with_expiry top level.
module keyed_table_with_expiry_tb;
  import kte_pkg::*;

  localparam int SLOTS      = 16;
  localparam int POOL_PAIRS = 24;
  localparam int RAND_CMDS  = 900;

  // One script line: a command, how often to repeat it with a stepped key, and
  // optionally the result typed in by hand.
  typedef struct packed {
    req_t       req;
    logic [7:0] reps;
    logic       typed;
    rsp_t       want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  // Predictor copy of the table.
  logic              slot_used [SLOTS];
  logic [KEY_W-1:0]  slot_key  [SLOTS];
  logic [DIM_W-1:0]  slot_dim  [SLOTS];
  logic [PAY_W-1:0]  slot_pay  [SLOTS];
  logic [LIFE_W-1:0] slot_life [SLOTS];

  rsp_t        pending_rsp [$];
  script_row_t script [$];
  logic [KEY_W-1:0] pool_key [POOL_PAIRS];
  logic [DIM_W-1:0] pool_dim [POOL_PAIRS];

  int   mismatch_cnt = 0;
  int   rsp_seen = 0;
  logic calm = 1'b0;
  int   stall_left = 0;
  rsp_t got_rsp;
  rsp_t want_rsp;

  keyed_table_with_expiry dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Apply one command to the predictor table and return the result it should give.
  function automatic rsp_t table_apply(req_t r);
    rsp_t res;
    int   hit;
    int   free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == r.key && slot_dim[i] == r.dimension)
        hit = i;
      if (free_slot < 0 && !slot_used[i])
        free_slot = i;
    end
    res.status = STS_OK;
    case (r.cmd)
      CMD_INSERT: begin
        // The duplicate check wins over the full check.
        if (hit >= 0) begin
          res.status = STS_DUP;
        end else if (free_slot < 0) begin
          res.status = STS_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot]  = r.key;
          slot_dim[free_slot]  = r.dimension;
          slot_pay[free_slot]  = r.payload;
          slot_life[free_slot] = (r.lifespan == '0) ? DEFAULT_LIFESPAN : r.lifespan;
          res.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        if (hit < 0) begin
          res.status = STS_MISSING;
        end else begin
          res.ok = 1'b1;
          res.found_payload = slot_pay[hit];
          res.lifespan_left = slot_life[hit];
        end
      end
      CMD_ERASE: begin
        if (hit < 0) begin
          res.status = STS_MISSING;
        end else begin
          slot_used[hit] = 1'b0;
          res.ok = 1'b1;
        end
      end
      default: begin
        // Aging frees every entry whose lifespan runs out.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_life[i] <= r.elapsed_ms) begin
              slot_used[i] = 1'b0;
              res.expired_count = res.expired_count + 1'b1;
            end else begin
              slot_life[i] = slot_life[i] - r.elapsed_ms;
            end
          end
        end
        res.ok = 1'b1;
      end
    endcase
    return res;
  endfunction

  // Present one command, wait for its beat, and queue the result it should give.
  task automatic drive_cmd(req_t r, logic typed, rsp_t want);
    rsp_t predicted;
    int   gap;
    if (!calm && $urandom_range(0, 99) < 38) begin
      gap = $urandom_range(1, 24);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {r.elapsed_ms, r.lifespan, r.payload, r.dimension, r.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = table_apply(r);
    pending_rsp = {pending_rsp, (typed ? want : predicted)};
  endtask

  function automatic void add_row(cmd_t c, logic [15:0] k, logic [7:0] d, logic [31:0] p,
                                  logic [15:0] l, logic [15:0] e, logic [7:0] reps,
                                  logic typed, logic ok, status_t st, logic [31:0] fp,
                                  logic [15:0] fl, logic [8:0] ex);
    script_row_t row;
    row.req.cmd        = c;
    row.req.key        = k;
    row.req.dimension  = d;
    row.req.payload    = p;
    row.req.lifespan   = l;
    row.req.elapsed_ms = e;
    row.reps           = reps;
    row.typed          = typed;
    row.want.ok            = ok;
    row.want.status        = st;
    row.want.found_payload = fp;
    row.want.lifespan_left = fl;
    row.want.expired_count = ex;
    script = {script, row};
  endfunction

  // Result monitor: compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rsp.ok            = out_tuser[0];
      got_rsp.status        = status_t'(out_tuser[2:1]);
      got_rsp.found_payload = out_tdata[31:0];
      got_rsp.lifespan_left = out_tdata[47:32];
      got_rsp.expired_count = out_tdata[56:48];
      rsp_seen = rsp_seen + 1;
      if (pending_rsp.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("result %0d arrived with nothing expected: ok=%0b status=%0d",
                   rsp_seen, got_rsp.ok, got_rsp.status);
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (got_rsp.ok !== want_rsp.ok || got_rsp.status !== want_rsp.status ||
            got_rsp.found_payload !== want_rsp.found_payload ||
            got_rsp.lifespan_left !== want_rsp.lifespan_left ||
            got_rsp.expired_count !== want_rsp.expired_count) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10) begin
            $display("result %0d: expected ok=%0b st=%0d pay=%h left=%0d exp=%0d",
                     rsp_seen, want_rsp.ok, want_rsp.status, want_rsp.found_payload,
                     want_rsp.lifespan_left, want_rsp.expired_count);
            $display("result %0d: got      ok=%0b st=%0d pay=%h left=%0d exp=%0d",
                     rsp_seen, got_rsp.ok, got_rsp.status, got_rsp.found_payload,
                     got_rsp.lifespan_left, got_rsp.expired_count);
          end
        end
      end
    end
  end

  // Result back-pressure: random stalls and an occasional long one; none begins while calm.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 299) == 0) begin
      stall_left <= $urandom_range(20, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  // Stimulus and end of run.
  initial begin
    req_t r;
    rsp_t none;
    int   roll;
    int   idx;

    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_dim[i]  = '0;
      slot_pay[i]  = '0;
      slot_life[i] = '0;
    end
    for (int i = 0; i < POOL_PAIRS; i++) begin
      pool_key[i] = 16'($urandom);
      pool_dim[i] = 8'($urandom);
    end
    // Two pool pairs share a key so that only the dimension tells them apart.
    pool_key[1] = pool_key[0];
    pool_dim[1] = pool_dim[0] ^ 8'h01;

    // Directed script: empty table, extremes, duplicates, default lifespan, expiry,
    // a full table, duplicate on a full table, and aging that clears everything.
    add_row(CMD_FIND,   16'h0000, 8'h00, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b0, STS_MISSING, 32'h0, 16'h0, 9'd0);
    add_row(CMD_AGE,    16'h0000, 8'h00, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'h0000, 8'h00, 32'h0, 16'h1, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'h0000, 8'h00, 32'h5555_AAAA, 16'h10, 16'h0, 8'd1, 1'b1,
            1'b0, STS_DUP, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'h0001, 8'h00, 32'h1234_5678, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_FIND,   16'h0001, 8'h00, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h1234_5678, 16'd1000, 9'd0);
    add_row(CMD_AGE,    16'h0000, 8'h00, 32'h0, 16'h0, 16'h1, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd1);
    add_row(CMD_FIND,   16'hFFFF, 8'hFF, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'hFFFF_FFFF, 16'hFFFE, 9'd0);
    add_row(CMD_ERASE,  16'hFFFF, 8'h00, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b0, STS_MISSING, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'h0100, 8'h5A, 32'hC3C3_0000, 16'd500, 16'h0, 8'd14, 1'b0,
            1'b0, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'h7777, 8'h77, 32'h0, 16'h5, 16'h0, 8'd1, 1'b1,
            1'b0, STS_FULL, 32'h0, 16'h0, 9'd0);
    add_row(CMD_INSERT, 16'hFFFF, 8'hFF, 32'h0, 16'h5, 16'h0, 8'd1, 1'b1,
            1'b0, STS_DUP, 32'h0, 16'h0, 9'd0);
    add_row(CMD_ERASE,  16'h0001, 8'h00, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd0);
    add_row(CMD_AGE,    16'h0000, 8'h00, 32'h0, 16'h0, 16'hFFFF, 8'd1, 1'b1,
            1'b1, STS_OK, 32'h0, 16'h0, 9'd15);
    add_row(CMD_FIND,   16'h0100, 8'h5A, 32'h0, 16'h0, 16'h0, 8'd1, 1'b1,
            1'b0, STS_MISSING, 32'h0, 16'h0, 9'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[n]) begin
      for (int j = 0; j < script[n].reps; j++) begin
        r = script[n].req;
        r.key = r.key + 16'(j);
        r.payload = r.payload ^ 32'(j);
        r.lifespan = r.lifespan + 16'(j);
        drive_cmd(r, script[n].typed, script[n].want);
      end
    end

    // Random commands, mostly on a small pool of pairs so that hits, duplicates,
    // a full table and expiry all come up often.
    for (int n = 0; n < RAND_CMDS; n++) begin
      calm <= (n >= 400 && n < 550);
      if ($urandom_range(0, 99) < 80) begin
        idx = $urandom_range(0, POOL_PAIRS - 1);
        r.key = pool_key[idx];
        r.dimension = pool_dim[idx];
      end else begin
        r.key = 16'($urandom);
        r.dimension = 8'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40)
        r.cmd = CMD_INSERT;
      else if (roll < 68)
        r.cmd = CMD_FIND;
      else if (roll < 86)
        r.cmd = CMD_ERASE;
      else
        r.cmd = CMD_AGE;
      r.payload = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 5)
        r.lifespan = '0;
      else if (roll < 10)
        r.lifespan = 16'hFFFF;
      else if (roll < 25)
        r.lifespan = 16'($urandom);
      else
        r.lifespan = 16'($urandom_range(1, 2500));
      if (r.cmd == CMD_AGE && $urandom_range(0, 99) < 88)
        r.elapsed_ms = 16'($urandom_range(0, 500));
      else
        r.elapsed_ms = 16'($urandom);
      drive_cmd(r, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
